/* rtl/slife_pkg.sv */
// ---------------------------------------------------------------------------
// slife_pkg
// Types and constants of the statistics-line idle field extractor: parse
// phases, status codes, the parser state record and the text characters.
// ---------------------------------------------------------------------------
package slife_pkg;

    // parse phase, one-hot
    typedef enum logic [2:0] {
        PH_SEEK = 3'b001,
        PH_RUNS = 3'b010,
        PH_READ = 3'b100
    } t_phase;

    // result status codes
    typedef enum logic [1:0] {
        ST_GO   = 2'd0,
        ST_STOP = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // full parser state
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  match_left;
        logic        prev_space;
        logic [2:0]  space_runs;
        logic [63:0] acc;
        t_status     status;
    } t_state;

    // keyword matching
    localparam logic [3:0] C_MATCH_INIT = 4'd4;
    localparam logic [3:0] C_MATCH_LEN  = 4'd5;
    localparam logic [3:0] C_MATCH_DEAD = 4'd15;

    // space run counting
    localparam logic [2:0] C_IDLE_RUN = 3'd4;
    localparam logic [2:0] C_RUNS_MAX = 3'd7;

    // characters
    localparam logic [7:0] C_CHAR_NUL   = 8'h00;
    localparam logic [7:0] C_CHAR_LF    = 8'h0A;
    localparam logic [7:0] C_CHAR_SPACE = 8'h20;
    localparam logic [7:0] C_CHAR_C     = 8'h63;
    localparam logic [7:0] C_CHAR_P     = 8'h70;
    localparam logic [7:0] C_CHAR_U     = 8'h75;
    localparam logic [7:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [7:0] C_CHAR_NINE  = 8'h39;

    // state at start of text, newline already matched
    localparam t_state C_STATE_RESET = '{
        phase:      PH_SEEK,
        match_left: C_MATCH_INIT,
        prev_space: 1'b0,
        space_runs: 3'd0,
        acc:        64'd0,
        status:     ST_GO
    };

    // expected character of "\ncpu " with match_left still to go
    function automatic logic [7:0] key_char(input logic [3:0] left);
        logic [7:0] ch;
        case (left)
            4'd5: ch = C_CHAR_LF;
            4'd4: ch = C_CHAR_C;
            4'd3: ch = C_CHAR_P;
            4'd2: ch = C_CHAR_U;
            4'd1: ch = C_CHAR_SPACE;
            default: ch = C_CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/slife_if.sv */
// ---------------------------------------------------------------------------
// slife_if
// Valid/ready channels of the extractor: text bytes in, status and value out.
// ---------------------------------------------------------------------------
interface slife_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       new_file;

    modport source (output valid, output text_byte, output new_file, input ready);
    modport sink   (input valid, input text_byte, input new_file, output ready);
endinterface

interface slife_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  parse_status;
    logic [63:0] idle_value;

    modport source (output valid, output parse_status, output idle_value, input ready);
    modport sink   (input valid, input parse_status, input idle_value, output ready);
endinterface

/* rtl/slife_step.sv */
// ---------------------------------------------------------------------------
// slife_step
// Next-state logic of the parser for one text byte: keyword match, space
// run count and decimal accumulation (times ten plus digit).
// ---------------------------------------------------------------------------
module slife_step (
    input  slife_pkg::t_state i_state,
    input  logic [7:0]        i_text_byte,
    input  logic              i_new_file,
    output slife_pkg::t_state o_state
);
    import slife_pkg::*;

    t_state      s;
    t_state      n;
    logic        done;
    logic        is_digit;
    logic [63:0] acc_next;
    logic [3:0]  left;
    logic        run_step;

    // digit test and times-ten update
    assign is_digit = (i_text_byte >= C_CHAR_ZERO) && (i_text_byte <= C_CHAR_NINE);
    assign acc_next = (s.acc << 3) + (s.acc << 1) + {60'd0, i_text_byte[3:0]};

    always_comb begin
        s        = i_new_file ? C_STATE_RESET : i_state;
        n        = s;
        done     = 1'b0;
        left     = s.match_left;
        run_step = 1'b0;

        if (s.status == ST_GO) begin
            // newline handling per phase
            if (i_text_byte == C_CHAR_LF) begin
                case (s.phase)
                    PH_SEEK: left = C_MATCH_LEN;
                    PH_RUNS: begin
                        n.status = ST_ERR;
                        done     = 1'b1;
                    end
                    PH_READ: begin
                        n.status = ST_STOP;
                        done     = 1'b1;
                    end
                    default: ;
                endcase
            end

            if (!done) begin
                case (s.phase)
                    PH_SEEK: begin
                        if (left >= 4'd1 && left <= C_MATCH_LEN) begin
                            if (i_text_byte == key_char(left)) begin
                                left = left - 4'd1;
                            end else begin
                                left = C_MATCH_DEAD;
                            end
                            if (left == 4'd0) begin
                                n.phase  = PH_RUNS;
                                run_step = 1'b1;
                            end
                        end
                        n.match_left = left;
                    end
                    PH_RUNS: run_step = 1'b1;
                    PH_READ: begin
                        if (is_digit) begin
                            n.acc = acc_next;
                        end else begin
                            n.status = ST_STOP;
                            done     = 1'b1;
                        end
                    end
                    default: ;
                endcase

                // space run counting
                if (run_step) begin
                    if (i_text_byte == C_CHAR_SPACE) begin
                        if (!s.prev_space && s.space_runs < C_RUNS_MAX) begin
                            n.space_runs = s.space_runs + 3'd1;
                        end
                        n.prev_space = 1'b1;
                    end else begin
                        if (s.space_runs == C_IDLE_RUN) begin
                            n.phase = PH_READ;
                            if (is_digit) begin
                                n.acc = acc_next;
                            end
                        end
                        n.prev_space = 1'b0;
                    end
                end
            end

            // nul byte ends the text unless a stop came first
            if (!done && i_text_byte == C_CHAR_NUL) begin
                n.status = ST_ERR;
            end
        end

        o_state = n;
    end

endmodule

/* rtl/stat_line_idle_field_extractor.sv */
// ---------------------------------------------------------------------------
// stat_line_idle_field_extractor
// Finds the "cpu " line of a statistics text, skips four space runs and
// returns the decimal idle field, one status and value per input byte.
//
//   channel | dir | payload                    | transfer
//   i_in    | in  | text_byte[7:0], new_file   | valid && ready
//   o_out   | out | parse_status[1:0],         | valid && ready
//           |     | idle_value[63:0]           |
//
// One byte per cycle while the output is not stalled. A byte is held in the
// input register, then the parser state and result register update together.
// Parser state update is one times-ten add plus a few byte compares.
// Reset (synchronous, active low) empties both registers and restores the
// start-of-text state. A stalled output holds the input register, which
// keeps taking bytes only as the result register drains.
// ---------------------------------------------------------------------------
module stat_line_idle_field_extractor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slife_in_if.sink          i_in,
    slife_out_if.source       o_out
);
    import slife_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_new;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_vld;
    t_status     r_status;
    logic [63:0] r_value;
    logic        s2_fire;
    logic        in_fire;

    // handshake
    assign s2_fire    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || s2_fire;
    assign in_fire    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
        if (in_fire) begin
            r_in_byte <= i_in.text_byte;
            r_in_new  <= i_in.new_file;
        end
    end

    // parser next state
    slife_step u_step (
        .i_state     (r_state),
        .i_text_byte (r_in_byte),
        .i_new_file  (r_in_new),
        .o_state     (n_state)
    );

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_RESET;
        end else if (s2_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (s2_fire) begin
            r_status <= n_state.status;
            r_value  <= n_state.acc;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.parse_status = r_status;
    assign o_out.idle_value   = r_value;

    // checks
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !s2_fire) |=> (r_in_vld && $stable(r_in_byte) && $stable(r_in_new)))
        else $error("input register changed while stalled");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s2_fire |=> $stable(r_state))
        else $error("parser state changed without a byte");

    a_final_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && !r_in_new && r_state.status != ST_GO) |=> $stable(r_state))
        else $error("finished parser state changed without new file");

    a_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire |=> (r_value == r_state.acc && r_status == r_state.status))
        else $error("result differs from parser state");

endmodule
